@@ src/jh2_pkg.sv @@
// shared types and constants for the two-dimensional joint histogram
`default_nettype none

package jh2_pkg;

  // payload widths
  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 16;
  localparam int BIN_IDX_W  = 16;
  localparam int COUNT_O_W  = 32;
  localparam int TOTAL_W    = 32;

  // register file
  localparam int SAMPLE_BITS_W = 5;
  localparam int BIN_BITS_W    = 4;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [1:0] REG_SAMPLE_BITS = 2'd0;
  localparam logic [1:0] REG_BIN_BITS    = 2'd1;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd2;

  localparam logic [SAMPLE_BITS_W-1:0] SAMPLE_BITS_RST = 5'd16;
  localparam logic [BIN_BITS_W-1:0]    BIN_BITS_RST    = 4'd8;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2,
    OP_IGNORE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS_W-1:0] sample_bits;
    logic [BIN_BITS_W-1:0]    bin_bits;
    logic                     signed_mode;
  } cfg_t;

  typedef struct packed {
    logic clr_en;
    logic load_item;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_t  op;
  } status_t;

endpackage

`default_nettype wire

@@ src/jh2_in_if.sv @@
// input channel carrying one histogram operation per item
`default_nettype none

interface jh2_in_if;
  import jh2_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [SAMPLE_W-1:0]  sample_a;
  logic [SAMPLE_W-1:0]  sample_b;
  logic [BIN_IDX_W-1:0] read_bin;

  modport source (output valid, operation, sample_a, sample_b, read_bin, input ready);
  modport sink   (input valid, operation, sample_a, sample_b, read_bin, output ready);
endinterface

`default_nettype wire

@@ src/jh2_out_if.sv @@
// result channel carrying one bin read per item
`default_nettype none

interface jh2_out_if;
  import jh2_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_echo;
  logic [COUNT_O_W-1:0] count;
  logic [TOTAL_W-1:0]   total;
  logic                 saturated;

  modport source (output valid, bin_echo, count, total, saturated, input ready);
  modport sink   (input valid, bin_echo, count, total, saturated, output ready);
endinterface

`default_nettype wire

@@ src/jh2_cfg.sv @@
// apb-style configuration registers
`default_nettype none

module jh2_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jh2_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [jh2_pkg::DATA_W-1:0]  pwdata,
  output logic      [jh2_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output jh2_pkg::cfg_t                    cfg
);
  import jh2_pkg::*;

  logic [SAMPLE_BITS_W-1:0] sample_bits_r, sample_bits_nxt;
  logic [BIN_BITS_W-1:0]    bin_bits_r, bin_bits_nxt;
  logic                     signed_mode_r, signed_mode_nxt;
  logic                     wr_en;
  logic [1:0]               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    sample_bits_nxt = sample_bits_r;
    bin_bits_nxt    = bin_bits_r;
    signed_mode_nxt = signed_mode_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_BITS: sample_bits_nxt = pwdata[SAMPLE_BITS_W-1:0];
        REG_BIN_BITS:    bin_bits_nxt    = pwdata[BIN_BITS_W-1:0];
        REG_SIGNED_MODE: signed_mode_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bits_r <= SAMPLE_BITS_RST;
      bin_bits_r    <= BIN_BITS_RST;
      signed_mode_r <= 1'b0;
    end else begin
      sample_bits_r <= sample_bits_nxt;
      bin_bits_r    <= bin_bits_nxt;
      signed_mode_r <= signed_mode_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_BITS: prdata = {{(DATA_W-SAMPLE_BITS_W){1'b0}}, sample_bits_r};
      REG_BIN_BITS:    prdata = {{(DATA_W-BIN_BITS_W){1'b0}}, bin_bits_r};
      REG_SIGNED_MODE: prdata = {{(DATA_W-1){1'b0}}, signed_mode_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.sample_bits = sample_bits_r;
  assign cfg.bin_bits    = bin_bits_r;
  assign cfg.signed_mode = signed_mode_r;

endmodule

`default_nettype wire

@@ src/jh2_ctrl.sv @@
// controller: clearing pass, item sequencing and result handshake
`default_nettype none

module jh2_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output jh2_pkg::cmd_t   cmd,
  input  wire jh2_pkg::status_t status
);
  import jh2_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_read;

  assign is_read = (status.op == OP_READ) || (status.op == OP_READ_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // a read waits here until the result register is free
        if (!is_read || !out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase

    if (cmd.commit && is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ src/jh2_dp.sv @@
// datapath: bin index, count memory, pair total and result register
`default_nettype none

module jh2_dp #(
  parameter int MAX_BIN_BITS = 8,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire jh2_pkg::cfg_t                  cfg,
  input  wire jh2_pkg::cmd_t                  cmd,
  output jh2_pkg::status_t                    status,
  input  wire logic [jh2_pkg::OP_W-1:0]       in_operation,
  input  wire logic [jh2_pkg::SAMPLE_W-1:0]   in_sample_a,
  input  wire logic [jh2_pkg::SAMPLE_W-1:0]   in_sample_b,
  input  wire logic [jh2_pkg::BIN_IDX_W-1:0]  in_read_bin,
  output logic      [jh2_pkg::BIN_IDX_W-1:0]  out_bin_echo,
  output logic      [jh2_pkg::COUNT_O_W-1:0]  out_count,
  output logic      [jh2_pkg::TOTAL_W-1:0]    out_total,
  output logic                                out_saturated
);
  import jh2_pkg::*;

  localparam int AW    = 2 * MAX_BIN_BITS;
  localparam int DEPTH = 1 << AW;
  localparam logic [BIN_BITS_W-1:0] MAX_BW = BIN_BITS_W'(MAX_BIN_BITS);

  function automatic logic [SAMPLE_W-1:0] coord(
    input logic [SAMPLE_W-1:0]      s,
    input logic [SAMPLE_BITS_W-1:0] sw,
    input logic [BIN_BITS_W-1:0]    bw,
    input logic                     sgn
  );
    logic [SAMPLE_W-1:0] mask;
    logic [SAMPLE_W-1:0] c;
    mask = {SAMPLE_W{1'b1}} >> (5'd16 - sw);
    c    = (s & mask) >> (sw - {1'b0, bw});
    if (sgn) c = c ^ (16'h0001 << (bw - 4'd1));
    return c;
  endfunction

  logic [COUNT_WIDTH-1:0]   bin_mem_r [DEPTH];
  logic [COUNT_WIDTH-1:0]   rd_data_r;
  logic [AW-1:0]            idx_r, idx_nxt, clr_cnt_r;
  op_t                      op_r;
  logic [TOTAL_W-1:0]       total_r;

  logic [SAMPLE_BITS_W-1:0] sw;
  logic [BIN_BITS_W-1:0]    bw;
  logic [SAMPLE_W-1:0]      coord_a, coord_b;
  logic [31:0]              grid_mask, add_idx, rd_idx;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [COUNT_WIDTH-1:0]   mem_wdata, cnt_inc;
  logic                     cnt_full, load_out;
  logic [AW+BIN_IDX_W-1:0]      echo_ext;
  logic [COUNT_WIDTH+COUNT_O_W-1:0] cnt_ext;

  // effective widths: container clamped to 1..16, bins to 1..max and to container
  always_comb begin
    if (cfg.sample_bits == '0)       sw = 5'd1;
    else if (cfg.sample_bits > 5'd16) sw = 5'd16;
    else                             sw = cfg.sample_bits;

    if (cfg.bin_bits == '0)          bw = 4'd1;
    else if (cfg.bin_bits > MAX_BW)  bw = MAX_BW;
    else                             bw = cfg.bin_bits;
    if ({1'b0, bw} > sw)             bw = sw[BIN_BITS_W-1:0];
  end

  assign coord_a   = coord(in_sample_a, sw, bw, cfg.signed_mode);
  assign coord_b   = coord(in_sample_b, sw, bw, cfg.signed_mode);
  assign grid_mask = (32'h1 << {bw, 1'b0}) - 32'h1;
  assign add_idx   = (({16'h0, coord_a} << bw) | {16'h0, coord_b}) & grid_mask;
  assign rd_idx    = {16'h0, in_read_bin} & grid_mask;
  assign idx_nxt   = (op_t'(in_operation) == OP_ADD) ? add_idx[AW-1:0] : rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= op_t'(in_operation);
      idx_r <= idx_nxt;
    end
  end

  assign cnt_full = (rd_data_r == {COUNT_WIDTH{1'b1}});
  assign cnt_inc  = cnt_full ? rd_data_r : rd_data_r + COUNT_WIDTH'(1);
  assign load_out = cmd.commit && ((op_r == OP_READ) || (op_r == OP_READ_CLEAR));

  assign mem_we    = cmd.clr_en ||
                     (cmd.commit && ((op_r == OP_ADD) || (op_r == OP_READ_CLEAR)));
  assign mem_waddr = cmd.clr_en ? clr_cnt_r : idx_r;
  assign mem_wdata = (!cmd.clr_en && op_r == OP_ADD) ? cnt_inc : '0;

  // count memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) bin_mem_r[mem_waddr] <= mem_wdata;
    rd_data_r <= bin_mem_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      total_r   <= '0;
    end else begin
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.commit && op_r == OP_ADD && total_r != {TOTAL_W{1'b1}})
        total_r <= total_r + TOTAL_W'(1);
    end
  end

  assign echo_ext = {{BIN_IDX_W{1'b0}}, idx_r};
  assign cnt_ext  = {{COUNT_O_W{1'b0}}, rd_data_r};

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bin_echo  <= echo_ext[BIN_IDX_W-1:0];
      out_count     <= cnt_ext[COUNT_O_W-1:0];
      out_total     <= total_r;
      out_saturated <= cnt_full;
    end
  end

  assign status.clr_last = (clr_cnt_r == {AW{1'b1}});
  assign status.op       = op_r;

endmodule

`default_nettype wire

@@ src/joint_histogram_2d.sv @@
// top level of the two-dimensional joint histogram
`default_nettype none

// Counts sample pairs into a grid of 2^bin_bits by 2^bin_bits bins held in an
// on-chip memory of 2^(2*MAX_BIN_BITS) counts, COUNT_WIDTH bits each. An add
// item keeps the top bin_bits bits of each sample's sample_bits-wide container
// (row from sample_a, column from sample_b), flips the top coordinate bit in
// signed mode, and increments that bin; bin counts and the 32-bit pair total
// saturate. A read item returns the bin's count, the pair total and a
// saturation flag; read-and-clear also zeroes the bin. Code 3 is swallowed.
// After reset a clearing pass writes zero to every bin, one per cycle, before
// the first item is taken; configuration writes are taken throughout. Each
// item then goes through accept and index, registered memory read, then the
// read-modify-write back to the count memory. A read stays in its last step
// while the previous result is still waiting on the result channel; a
// finished result sits in its own register, so the next item can be taken
// while it waits. Registers: sample_bits at 0x0, bin_bits at 0x4, signed_mode
// at 0x8; write them only while the block is idle.

module joint_histogram_2d #(
  parameter int MAX_BIN_BITS = 8,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  jh2_in_if.sink                            in_ch,
  jh2_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jh2_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [jh2_pkg::DATA_W-1:0]   pwdata,
  output logic      [jh2_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);
  import jh2_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  // register file
  jh2_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencing of the clearing pass and of each item
  jh2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // index arithmetic, count memory and result register
  jh2_dp #(
    .MAX_BIN_BITS (MAX_BIN_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .in_operation  (in_ch.operation),
    .in_sample_a   (in_ch.sample_a),
    .in_sample_b   (in_ch.sample_b),
    .in_read_bin   (in_ch.read_bin),
    .out_bin_echo  (out_ch.bin_echo),
    .out_count     (out_ch.count),
    .out_total     (out_ch.total),
    .out_saturated (out_ch.saturated)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
